@@ rtl/core/led_matrix_dirty_row_refresh_top_assert.svh @@
// ----------------------------------------------------------------------------
// led_matrix_dirty_row_refresh_top_assert.svh
// Assertion macros for the LED matrix dirty-row refresh controller.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_DIRTY_ROW_REFRESH_TOP_ASSERT_SVH
`define LED_MATRIX_DIRTY_ROW_REFRESH_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define LMDR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LMDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lmdr_pkg.sv @@
// ----------------------------------------------------------------------------
// lmdr_pkg
// Shared constants, types and helpers for the LED matrix dirty-row refresh.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmdr_pkg;

    localparam int MAX_DEVICES = 8;
    localparam int ROW_COUNT   = 8;
    localparam int ROW_W       = $clog2(ROW_COUNT);
    localparam int DEV_W       = $clog2(MAX_DEVICES);
    localparam int ADDR_W      = ROW_W + DEV_W;
    localparam int DATA_W      = 8;
    localparam int CNT_W       = 4;
    localparam int WORD_W      = 12;

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Shadow store access request
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } shadow_req_t;

    // Device count clamped to 1..MAX_DEVICES
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] n;
        n = cnt;
        if (cnt == '0) begin
            n = CNT_W'(1);
        end else if (cnt > CNT_W'(MAX_DEVICES)) begin
            n = CNT_W'(MAX_DEVICES);
        end
        return n;
    endfunction

    // One bit per active device
    function automatic logic [MAX_DEVICES-1:0] active_mask(input logic [CNT_W-1:0] n);
        logic [MAX_DEVICES-1:0] m;
        for (int i = 0; i < MAX_DEVICES; i++) begin
            m[i] = (CNT_W'(i) < n);
        end
        return m;
    endfunction

    // Rows strictly above the given row
    function automatic logic [ROW_COUNT-1:0] rows_above(input logic [ROW_W-1:0] row);
        logic [ROW_COUNT-1:0] m;
        for (int i = 0; i < ROW_COUNT; i++) begin
            m[i] = (ROW_W'(i) > row);
        end
        return m;
    endfunction

    // Index of the lowest set bit (0 when none)
    function automatic logic [ROW_W-1:0] lowest_row(input logic [ROW_COUNT-1:0] vec);
        logic [ROW_W-1:0] idx;
        idx = '0;
        for (int i = ROW_COUNT - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = ROW_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/core/lmdr_shadow_store.sv @@
// ----------------------------------------------------------------------------
// lmdr_shadow_store
// Shadow byte memory, one entry per (row, device), registered read port.
// Per-entry valid bits make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmdr_shadow_store (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lmdr_pkg::shadow_req_t        req,
    output logic [lmdr_pkg::DATA_W-1:0]  rd_data
);

    localparam int DEPTH = lmdr_pkg::ROW_COUNT * lmdr_pkg::MAX_DEVICES;

    logic [lmdr_pkg::DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]            valid_reg;
    logic [lmdr_pkg::DATA_W-1:0] rd_data_reg;
    logic                        rd_valid_reg;

    // Memory array: write port and registered read port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // Valid bits, cleared at once by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/core/led_matrix_dirty_row_refresh_top.sv @@
// A write item reads the shadow byte on acceptance; the byte is compared and
// written back in the next cycle, from the registered read port of the
// shadow memory. A flush item emits n words per dirty row (n the effective
// device count, so up to 64 words in all), as the shadow memory read port
// delivers one byte per cycle while the output does not stall. A flush with
// no dirty row finishes in its acceptance cycle. A finished word waits in
// the output register while the next item can already be taken. No clearing
// pass follows reset.
// ----------------------------------------------------------------------------
// led_matrix_dirty_row_refresh_top
// Dirty-row refresh controller for a chain of 8x8 LED matrix drivers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "led_matrix_dirty_row_refresh_top_assert.svh"

module led_matrix_dirty_row_refresh_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [lmdr_pkg::CNT_W-1:0]        cfg_wdata,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic [lmdr_pkg::ROW_W-1:0]        s_row_index,
    input  logic [lmdr_pkg::DEV_W-1:0]        s_device_index,
    input  logic [lmdr_pkg::DATA_W-1:0]       s_row_value,
    // result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lmdr_pkg::WORD_W-1:0]       m_spi_word,
    output logic                              m_row_end,
    output logic                              m_last
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WR_CMP = 2'd1;
    localparam logic [1:0] ST_FL_OUT = 2'd2;

    localparam int ROWS  = lmdr_pkg::ROW_COUNT;
    localparam int DEVS  = lmdr_pkg::MAX_DEVICES;
    localparam int ROW_W = lmdr_pkg::ROW_W;
    localparam int DEV_W = lmdr_pkg::DEV_W;
    localparam int CNT_W = lmdr_pkg::CNT_W;

    logic [1:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              count_reg;
    logic [ROWS-1:0][DEVS-1:0]     dirty_reg, dirty_next;
    logic [ROW_W-1:0]              row_reg, row_next;
    logic [DEV_W-1:0]              dev_reg, dev_next;
    logic [lmdr_pkg::DATA_W-1:0]   val_reg, val_next;

    logic                          m_valid_reg, m_valid_next;
    logic [lmdr_pkg::WORD_W-1:0]   m_word_reg, m_word_next;
    logic                          m_row_end_reg, m_row_end_next;
    logic                          m_last_reg, m_last_next;

    lmdr_pkg::shadow_req_t         req;
    logic [lmdr_pkg::DATA_W-1:0]   rd_data;

    logic [CNT_W-1:0]              n_eff;
    logic [DEVS-1:0]               act_mask;
    logic [DEV_W-1:0]              last_dev;
    logic [ROWS-1:0]               row_nz;
    logic [ROWS-1:0]               rows_left;
    logic                          accept;
    logic                          dev_ok;
    logic                          out_free;
    logic                          out_load;
    logic                          flush_done;
    logic                          word_row_end;
    logic [lmdr_pkg::WORD_W-1:0]   word_val;

    // Shadow byte memory
    lmdr_shadow_store u_shadow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_data (rd_data)
    );

    // Chain size and row status
    assign n_eff    = lmdr_pkg::eff_count(count_reg);
    assign act_mask = lmdr_pkg::active_mask(n_eff);
    assign last_dev = DEV_W'(n_eff - CNT_W'(1));
    assign dev_ok   = ({1'b0, s_device_index} < n_eff);

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            row_nz[r] = |(dirty_reg[r] & act_mask);
        end
    end

    assign rows_left = row_nz & lmdr_pkg::rows_above(row_reg);

    // Handshakes
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Word for the byte now at the memory output
    assign word_row_end = (dev_reg == last_dev);
    assign word_val = dirty_reg[row_reg][dev_reg]
                    ? {(CNT_W'(row_reg) + CNT_W'(1)), rd_data}
                    : '0;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        dirty_next = dirty_reg;
        row_next   = row_reg;
        dev_next   = dev_reg;
        val_next   = val_reg;
        req        = '0;
        out_load   = 1'b0;
        flush_done = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_cmd == lmdr_pkg::CMD_WRITE) begin
                        if (dev_ok) begin
                            req.rd_en  = 1'b1;
                            req.rd_addr = {s_row_index, s_device_index};
                            row_next   = s_row_index;
                            dev_next   = s_device_index;
                            val_next   = s_row_value;
                            state_next = ST_WR_CMP;
                        end
                    end else if (|row_nz) begin
                        row_next    = lmdr_pkg::lowest_row(row_nz);
                        dev_next    = '0;
                        req.rd_en   = 1'b1;
                        req.rd_addr = {lmdr_pkg::lowest_row(row_nz), DEV_W'(0)};
                        state_next  = ST_FL_OUT;
                    end else begin
                        dirty_next = '0;
                        flush_done = 1'b1;
                    end
                end
            end
            ST_WR_CMP: begin
                // store only on change
                if (rd_data != val_reg) begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = {row_reg, dev_reg};
                    req.wr_data = val_reg;
                    dirty_next[row_reg][dev_reg] = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_FL_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (!word_row_end) begin
                        dev_next    = dev_reg + DEV_W'(1);
                        req.rd_en   = 1'b1;
                        req.rd_addr = {row_reg, dev_reg + DEV_W'(1)};
                    end else if (|rows_left) begin
                        row_next    = lmdr_pkg::lowest_row(rows_left);
                        dev_next    = '0;
                        req.rd_en   = 1'b1;
                        req.rd_addr = {lmdr_pkg::lowest_row(rows_left), DEV_W'(0)};
                    end else begin
                        dirty_next = '0;
                        flush_done = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_word_next    = m_word_reg;
        m_row_end_next = m_row_end_reg;
        m_last_next    = m_last_reg;
        if (out_load) begin
            m_valid_next   = 1'b1;
            m_word_next    = word_val;
            m_row_end_next = word_row_end;
            m_last_next    = word_row_end && (rows_left == '0);
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= CNT_W'(lmdr_pkg::MAX_DEVICES);
            dirty_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dirty_reg   <= dirty_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        row_reg       <= row_next;
        dev_reg       <= dev_next;
        val_reg       <= val_next;
        m_word_reg    <= m_word_next;
        m_row_end_reg <= m_row_end_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_spi_word = m_word_reg;
    assign m_row_end  = m_row_end_reg;
    assign m_last     = m_last_reg;

    // Checks
    `LMDR_ASSERT_NOW(a_last_ends_row, m_valid && m_last, m_row_end, "last word not at row end")
    `LMDR_ASSERT_NOW(a_word_row_range, m_valid && (m_spi_word != '0),
        (m_spi_word[11:8] != 4'd0) && (m_spi_word[11:8] <= 4'd8), "bad row register in word")
    `LMDR_ASSERT_NEXT(a_flush_clears, flush_done, dirty_reg == '0, "dirty masks left after flush")
    `LMDR_ASSERT_NEXT(a_bad_dev_ignored,
        accept && (s_cmd == lmdr_pkg::CMD_WRITE) && !dev_ok,
        (state_reg == ST_IDLE) && $stable(dirty_reg), "write to inactive device acted")

endmodule
